FILE: sv/vneg_pkg.sv
`timescale 1ns / 1ps
package vneg_pkg;

  localparam int IDX_W = 18;
  localparam int VAL_W = 16;
  localparam int DIM_W = 7;
  localparam int RC_W  = 14;
  localparam int WGT_W = 17;

  // Configuration register indexes
  localparam logic [1:0] CFG_ROWS   = 2'd0;
  localparam logic [1:0] CFG_COLS   = 2'd1;
  localparam logic [1:0] CFG_SLICES = 2'd2;

  // Request kinds
  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_PROCESS = 1'b1;

  // Effective volume dimensions
  typedef struct packed {
    logic [DIM_W-1:0] nr;
    logic [DIM_W-1:0] nc;
    logic [DIM_W-1:0] ns;
    logic [RC_W-1:0]  rc;
  } vneg_dims_t;

  // Classified request passed from front to back; lo/hi are {slice, col, row}
  typedef struct packed {
    logic             wr;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic             oor;
    logic [2:0]       lo;
    logic [2:0]       hi;
  } vneg_req_t;

endpackage

FILE: sv/vneg_front.sv
`timescale 1ns / 1ps
module vneg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  vneg_pkg::vneg_dims_t dims,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_type,
  input  logic [17:0]         in_index,
  input  logic [15:0]         in_value,
  output logic                push,
  output vneg_pkg::vneg_req_t push_req,
  input  logic                q_full
);
  import vneg_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_DIV_S, F_DIV_C, F_PUSH} fstate_t;

  fstate_t          state_r;
  logic             type_r;
  logic [IDX_W-1:0] idx_r;
  logic [VAL_W-1:0] val_r;
  logic [IDX_W:0]   rem_r;
  logic [IDX_W-1:0] quo_r;
  logic [4:0]       cnt_r;
  logic [IDX_W-1:0] s_r;
  logic [DIM_W-1:0] c_r;
  logic [DIM_W-1:0] r_r;

  logic [IDX_W:0]   shifted;
  logic [IDX_W:0]   divisor;
  logic             ge;
  logic [IDX_W:0]   rem_n;
  logic [IDX_W-1:0] quo_n;
  logic             last_step;

  assign in_ready = (state_r == F_IDLE);

  // One restoring division step, shared by the slice and column divisions
  always_comb begin
    shifted   = {rem_r[IDX_W-1:0], quo_r[IDX_W-1]};
    divisor   = (state_r == F_DIV_S) ? (IDX_W+1)'(dims.rc) : (IDX_W+1)'(dims.nr);
    ge        = (shifted >= divisor);
    rem_n     = ge ? (shifted - divisor) : shifted;
    quo_n     = {quo_r[IDX_W-2:0], ge};
    last_step = (cnt_r == 5'(IDX_W - 1));
  end

  // Build the request for the back part
  always_comb begin
    push              = (state_r == F_PUSH) && !q_full;
    push_req.wr       = (type_r == REQ_WRITE);
    push_req.idx      = idx_r;
    push_req.val      = val_r;
    push_req.oor      = (s_r >= IDX_W'(dims.ns));
    push_req.lo       = {s_r != '0, c_r != '0, r_r != '0};
    push_req.hi       = {(s_r + 1'b1) < IDX_W'(dims.ns),
                         ({1'b0, c_r} + 1'b1) < {1'b0, dims.nc},
                         ({1'b0, r_r} + 1'b1) < {1'b0, dims.nr}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            type_r <= in_type;
            idx_r  <= in_index;
            val_r  <= in_value;
            quo_r  <= in_index;
            rem_r  <= '0;
            cnt_r  <= '0;
            state_r <= (in_type == REQ_PROCESS) ? F_DIV_S : F_PUSH;
          end
        end
        F_DIV_S: begin
          if (last_step) begin
            s_r     <= quo_n;
            quo_r   <= rem_n[IDX_W-1:0];
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= F_DIV_C;
          end else begin
            cnt_r <= cnt_r + 1'b1;
            rem_r <= rem_n;
            quo_r <= quo_n;
          end
        end
        F_DIV_C: begin
          cnt_r <= cnt_r + 1'b1;
          if (last_step) begin
            c_r     <= quo_n[DIM_W-1:0];
            r_r     <= rem_n[DIM_W-1:0];
            state_r <= F_PUSH;
          end else begin
            rem_r <= rem_n;
            quo_r <= quo_n;
          end
        end
        F_PUSH: begin
          if (!q_full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/vneg_queue.sv
`timescale 1ns / 1ps
module vneg_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  vneg_pkg::vneg_req_t push_req,
  output logic                full,
  input  logic                pop,
  output vneg_pkg::vneg_req_t head,
  output logic                empty
);
  import vneg_pkg::*;

  vneg_req_t  ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rp_r];

  // Two-entry request queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        ent_r[wp_r] <= push_req;
        wp_r        <= ~wp_r;
      end
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: sv/vneg_back.sv
`timescale 1ns / 1ps
module vneg_back #(
  parameter int DIM_MAX    = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vneg_pkg::vneg_dims_t dims,
  input  vneg_pkg::vneg_req_t head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [17:0]         out_centre,
  output logic [17:0]         out_nbr,
  output logic [16:0]         out_weight,
  output logic                out_has,
  output logic                out_last
);
  import vneg_pkg::*;

  localparam longint FULL_DEPTH  = longint'(DIM_MAX) * DIM_MAX * DIM_MAX;
  localparam longint STORE_DEPTH = (FULL_DEPTH > (64'd1 << IDX_W)) ?
                                   (64'd1 << IDX_W) : FULL_DEPTH;
  localparam int     AW          = $clog2(STORE_DEPTH);

  typedef enum logic [1:0] {B_IDLE, B_CENTRE, B_WALK, B_END} bstate_t;

  logic [VALUE_BITS-1:0] mem [STORE_DEPTH];
  logic [VALUE_BITS-1:0] rdata_r;
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         mem_addr;
  logic [VALUE_BITS-1:0] mem_wdata;

  bstate_t               state_r;
  logic [IDX_W-1:0]      cidx_r;
  logic [VALUE_BITS-1:0] cv_r;
  logic [2:0]            lo_r;
  logic [2:0]            hi_r;
  logic [1:0]            ks_r;
  logic [1:0]            kc_r;
  logic [1:0]            kr_r;
  logic                  walk_done_r;
  logic                  rd_v_r;
  logic [IDX_W-1:0]      rd_nidx_r;
  logic                  pend_v_r;
  logic [IDX_W-1:0]      pend_nidx_r;
  logic [WGT_W-1:0]      pend_w_r;
  logic                  out_valid_r;

  logic                  out_free;
  logic                  excluded;
  logic                  cand_ok;
  logic                  issue;
  logic                  consume;
  logic                  emit;
  logic [IDX_W-1:0]      s_sum;
  logic [IDX_W-1:0]      c_sum;
  logic [IDX_W-1:0]      nidx;
  logic [VALUE_BITS:0]   wsum;
  logic                  start_ok;

  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign excluded  = (rdata_r == {VALUE_BITS{1'b1}});
  assign wsum      = {1'b0, rdata_r} + {1'b0, cv_r};

  // Neighbour candidate at the current walk position
  always_comb begin
    cand_ok = !walk_done_r &&
              (ks_r != 2'd0 || lo_r[2]) && (ks_r != 2'd2 || hi_r[2]) &&
              (kc_r != 2'd0 || lo_r[1]) && (kc_r != 2'd2 || hi_r[1]) &&
              (kr_r != 2'd0 || lo_r[0]) && (kr_r != 2'd2 || hi_r[0]) &&
              !(ks_r == 2'd1 && kc_r == 2'd1 && kr_r == 2'd1);
    case (ks_r)
      2'd0:    s_sum = cidx_r - IDX_W'(dims.rc);
      2'd2:    s_sum = cidx_r + IDX_W'(dims.rc);
      default: s_sum = cidx_r;
    endcase
    case (kc_r)
      2'd0:    c_sum = s_sum - IDX_W'(dims.nr);
      2'd2:    c_sum = s_sum + IDX_W'(dims.nr);
      default: c_sum = s_sum;
    endcase
    case (kr_r)
      2'd0:    nidx = c_sum - 1'b1;
      2'd2:    nidx = c_sum + 1'b1;
      default: nidx = c_sum;
    endcase
    consume = (state_r == B_WALK) && rd_v_r && (excluded || !pend_v_r || out_free);
    issue   = (state_r == B_WALK) && cand_ok && (!rd_v_r || consume);
    emit    = ((state_r == B_WALK) && consume && !excluded && pend_v_r) ||
              ((state_r == B_END) && out_free);
  end

  // Memory port control
  always_comb begin
    pop       = (state_r == B_IDLE) && !empty;
    start_ok  = pop && !head.wr && !head.oor;
    mem_we    = pop && head.wr && (64'(head.idx) < STORE_DEPTH);
    mem_re    = start_ok || issue;
    mem_addr  = issue ? nidx[AW-1:0] : head.idx[AW-1:0];
    mem_wdata = VALUE_BITS'(head.val);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      walk_done_r <= 1'b0;
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (pop && !head.wr) begin
            cidx_r   <= head.idx;
            lo_r     <= head.lo;
            hi_r     <= head.hi;
            pend_v_r <= 1'b0;
            state_r  <= head.oor ? B_END : B_CENTRE;
          end
        end
        B_CENTRE: begin
          cv_r        <= rdata_r;
          ks_r        <= '0;
          kc_r        <= '0;
          kr_r        <= '0;
          walk_done_r <= 1'b0;
          rd_v_r      <= 1'b0;
          state_r     <= excluded ? B_END : B_WALK;
        end
        B_WALK: begin
          // advance the walk when the candidate is skipped or issued
          if (!walk_done_r && (!cand_ok || issue)) begin
            if (kr_r == 2'd2) begin
              kr_r <= '0;
              if (kc_r == 2'd2) begin
                kc_r <= '0;
                if (ks_r == 2'd2) walk_done_r <= 1'b1;
                else ks_r <= ks_r + 1'b1;
              end else begin
                kc_r <= kc_r + 1'b1;
              end
            end else begin
              kr_r <= kr_r + 1'b1;
            end
          end
          if (issue) begin
            rd_v_r    <= 1'b1;
            rd_nidx_r <= nidx;
          end else if (consume) begin
            rd_v_r <= 1'b0;
          end
          // hold the newest edge back until its last flag is known
          if (consume && !excluded) begin
            if (pend_v_r) begin
              out_centre  <= cidx_r;
              out_nbr     <= pend_nidx_r;
              out_weight  <= pend_w_r;
              out_has     <= 1'b1;
              out_last    <= 1'b0;
            end
            pend_v_r    <= 1'b1;
            pend_nidx_r <= rd_nidx_r;
            pend_w_r    <= WGT_W'(wsum);
          end
          if (walk_done_r && !rd_v_r) state_r <= B_END;
        end
        B_END: begin
          if (out_free) begin
            out_centre  <= cidx_r;
            out_nbr     <= pend_v_r ? pend_nidx_r : '0;
            out_weight  <= pend_v_r ? pend_w_r : '0;
            out_has     <= pend_v_r;
            out_last    <= 1'b1;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/voxel_neighbour_edge_generator.sv
`timescale 1ns / 1ps
// Voxel neighbour edge generator. Write requests (tuser 0) store one intensity
// per voxel; process requests (tuser 1) emit one edge per in-bounds,
// non-excluded neighbour of the named centre, walked slice, column, row, with
// tlast on the final result of each run and a single no-edge result when the
// centre is out of range, excluded or isolated. The voxel store is not cleared
// at reset; read only voxels that were written. In the front end a process
// request passes through two 18-step restoring divisions that split the index
// into slice, column and row. The back end then reads the centre from the
// single store port, walks the 27 neighbourhood positions, reading each
// in-bounds neighbour, and drains the last read and sends the final result.
// The two ends overlap through a two-entry queue, so the front end can split
// a new process request while the back end still works on an earlier one.
module voxel_neighbour_edge_generator #(
  parameter int DIM_MAX    = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // voxel_index[17:0], voxel_value[33:18], zero pad
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // centre_index[17:0], neighbour_index[35:18],
                                  // edge_weight_x2[52:36], zero pad
  output logic        out_tuser,  // has_edge
  output logic        out_tlast   // last_of_run
);
  import vneg_pkg::*;

  localparam int DMAX = (DIM_MAX > 127) ? 127 : DIM_MAX;

  logic [DIM_W-1:0] rows_r;
  logic [DIM_W-1:0] cols_r;
  logic [DIM_W-1:0] slices_r;
  logic [RC_W-1:0]  rc_r;
  vneg_dims_t       dims;
  vneg_req_t        push_req;
  vneg_req_t        head;
  logic             push;
  logic             q_full;
  logic             q_empty;
  logic             pop;
  logic [17:0]      o_centre;
  logic [17:0]      o_nbr;
  logic [16:0]      o_weight;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v < DIM_W'(3)) return DIM_W'(3);
    if (v > DIM_W'(DMAX)) return DIM_W'(DMAX);
    return v;
  endfunction

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= DIM_W'(3);
      cols_r   <= DIM_W'(3);
      slices_r <= DIM_W'(3);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROWS:   rows_r   <= cfg_data;
        CFG_COLS:   cols_r   <= cfg_data;
        CFG_SLICES: slices_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective dimensions and slice size
  always_comb begin
    dims.nr = clamp_dim(rows_r);
    dims.nc = clamp_dim(cols_r);
    dims.ns = clamp_dim(slices_r);
    dims.rc = rc_r;
  end

  always_ff @(posedge clk) begin
    rc_r <= RC_W'({7'b0, dims.nr} * {7'b0, dims.nc});
  end

  vneg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .dims     (dims),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_type  (in_tuser),
    .in_index (in_tdata[17:0]),
    .in_value (in_tdata[33:18]),
    .push     (push),
    .push_req (push_req),
    .q_full   (q_full)
  );

  vneg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  vneg_back #(
    .DIM_MAX    (DIM_MAX),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .dims       (dims),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_centre (o_centre),
    .out_nbr    (o_nbr),
    .out_weight (o_weight),
    .out_has    (out_tuser),
    .out_last   (out_tlast)
  );

  assign out_tdata = {3'b0, o_weight, o_nbr, o_centre};

endmodule
